>>> rtl/core/robi_pkg.sv
`default_nettype none
package robi_pkg;

   localparam int unsigned CW = 32;
   localparam int unsigned EW = 31;
   localparam int unsigned RW = 16;
   localparam int unsigned DW = CW + 1;
   localparam int unsigned PW = DW + RW;
   localparam int unsigned SW = PW + 1;
   localparam int unsigned LW = 38;
   localparam int unsigned NW = LW + 1;
   localparam int unsigned FB = 16;
   localparam int unsigned QW = LW + FB;
   localparam int unsigned DIV_BITS = QW;
   localparam int unsigned TW = QW + 3;
   localparam int unsigned HFW = 17;
   localparam int unsigned RND_SHIFT = 13;

   localparam logic signed [SW-1:0] RND_HALF = SW'(4096);
   localparam logic signed [TW-1:0] T_INF = TW'(1) <<< (QW + 1);
   localparam logic signed [TW-1:0] FRAC_ONE = TW'(65536);

   typedef struct packed {
      logic signed [RW-1:0] c;
      logic signed [RW-1:0] s;
      logic                 dx_neg;
      logic                 dy_neg;
      logic [3:0]           q_neg;
      logic                 zx;
      logic                 zy;
      logic                 miss;
   } side_type;

   typedef struct packed {
      logic [3:0][LW-1:0] rem;
      logic [3:0][QW-1:0] quo;
      logic [1:0][LW-1:0] dvs;
      side_type           side;
   } div_type;

endpackage
`default_nettype wire

>>> rtl/core/ray_oriented_box_intersection.sv
// Channel  Direction  Handshake              Word
// req      in         req_tvalid/req_tready  segment, box center, extents, cos/sin
// rsp      out        rsp_tvalid/rsp_tready  tuser hit, tdata fraction and normal
//
// One word is accepted per cycle unless rsp_tready back-pressure stalls stage zero.
// The core is the 54-stage restoring divider, one quotient bit per stage.
// Reset clears every stage valid bit; the data registers are not reset.
// Each stage holds only while its successor is full and stalled, so bubbles
// close up; a stalled result holds back earlier words only as the stages fill.
`default_nettype none
module ray_oriented_box_intersection (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // ray_start_x, ray_start_y, ray_finish_x, ray_finish_y, box_center_x,
   // box_center_y, box_width, box_height, rot_cos, rot_sin, zero fill.
   input  wire logic [287:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // hit_fraction, normal_x, normal_y, zero fill.
   output logic [55:0]       rsp_tdata,
   // hit.
   output logic              rsp_tuser
);

   localparam int unsigned NST = robi_pkg::DIV_BITS + 7;
   localparam int unsigned SD = robi_pkg::DIV_BITS + 3;

   logic [NST-1:0] v_ff, v_in, en;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_tready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_tvalid : v_ff[0];
      for (int k = 1; k < NST; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NST-1];

   // Stage one: offsets from the box center and the direction.
   logic signed [robi_pkg::DW-1:0] px_ff, py_ff, dx_ff, dy_ff;
   logic [robi_pkg::EW-1:0]        bw1_ff, bh1_ff;
   logic signed [robi_pkg::RW-1:0] c1_ff, s1_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         px_ff  <= 33'($signed(req_tdata[31:0])) - 33'($signed(req_tdata[159:128]));
         py_ff  <= 33'($signed(req_tdata[63:32])) - 33'($signed(req_tdata[191:160]));
         dx_ff  <= 33'($signed(req_tdata[95:64])) - 33'($signed(req_tdata[31:0]));
         dy_ff  <= 33'($signed(req_tdata[127:96])) - 33'($signed(req_tdata[63:32]));
         bw1_ff <= req_tdata[222:192];
         bh1_ff <= req_tdata[253:223];
         c1_ff  <= $signed(req_tdata[269:254]);
         s1_ff  <= $signed(req_tdata[285:270]);
      end
   end

   // Stage two: the rotation products.
   logic signed [robi_pkg::PW-1:0] pxc_ff, pys_ff, pyc_ff, pxs_ff;
   logic signed [robi_pkg::PW-1:0] dxc_ff, dys_ff, dyc_ff, dxs_ff;
   logic [robi_pkg::EW-1:0]        bw2_ff, bh2_ff;
   logic signed [robi_pkg::RW-1:0] c2_ff, s2_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pxc_ff <= px_ff * c1_ff;
         pys_ff <= py_ff * s1_ff;
         pyc_ff <= py_ff * c1_ff;
         pxs_ff <= px_ff * s1_ff;
         dxc_ff <= dx_ff * c1_ff;
         dys_ff <= dy_ff * s1_ff;
         dyc_ff <= dy_ff * c1_ff;
         dxs_ff <= dx_ff * s1_ff;
         bw2_ff <= bw1_ff;
         bh2_ff <= bh1_ff;
         c2_ff  <= c1_ff;
         s2_ff  <= s1_ff;
      end
   end

   // Stage three: local coordinates rounded to Q.17.
   logic signed [robi_pkg::LW-1:0] lsx_ff, lsy_ff, ldx_ff, ldy_ff;
   logic signed [robi_pkg::LW-1:0] lsx_in, lsy_in, ldx_in, ldy_in;
   logic [robi_pkg::EW-1:0]        bw3_ff, bh3_ff;
   logic signed [robi_pkg::RW-1:0] c3_ff, s3_ff;

   always_comb begin
      logic signed [robi_pkg::SW-1:0] sum_sx, sum_sy, sum_dx, sum_dy;
      sum_sx = robi_pkg::SW'(pxc_ff) + robi_pkg::SW'(pys_ff) + robi_pkg::RND_HALF;
      sum_sy = robi_pkg::SW'(pyc_ff) - robi_pkg::SW'(pxs_ff) + robi_pkg::RND_HALF;
      sum_dx = robi_pkg::SW'(dxc_ff) + robi_pkg::SW'(dys_ff) + robi_pkg::RND_HALF;
      sum_dy = robi_pkg::SW'(dyc_ff) - robi_pkg::SW'(dxs_ff) + robi_pkg::RND_HALF;
      lsx_in = robi_pkg::LW'(sum_sx >>> robi_pkg::RND_SHIFT);
      lsy_in = robi_pkg::LW'(sum_sy >>> robi_pkg::RND_SHIFT);
      ldx_in = robi_pkg::LW'(sum_dx >>> robi_pkg::RND_SHIFT);
      ldy_in = robi_pkg::LW'(sum_dy >>> robi_pkg::RND_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         lsx_ff <= lsx_in;
         lsy_ff <= lsy_in;
         ldx_ff <= ldx_in;
         ldy_ff <= ldy_in;
         bw3_ff <= bw2_ff;
         bh3_ff <= bh2_ff;
         c3_ff  <= c2_ff;
         s3_ff  <= s2_ff;
      end
   end

   // Stage four: slab numerators and divisor magnitudes enter the divider.
   robi_pkg::div_type dv_ff [robi_pkg::DIV_BITS+1];
   robi_pkg::div_type dv0_in;

   always_comb begin
      logic signed [robi_pkg::NW-1:0] hx, hy, sx, sy, hms_x, nhms_x, hms_y, nhms_y;
      logic signed [robi_pkg::NW-1:0] en_x, ex_x, en_y, ex_y;
      logic [3:0][robi_pkg::NW-1:0]   nums;
      logic                           in_x, in_y;
      hx = $signed({8'b0, bw3_ff});
      hy = $signed({8'b0, bh3_ff});
      sx = robi_pkg::NW'(lsx_ff);
      sy = robi_pkg::NW'(lsy_ff);
      hms_x = hx - sx;
      nhms_x = -hx - sx;
      hms_y = hy - sy;
      nhms_y = -hy - sy;
      en_x = ldx_ff[robi_pkg::LW-1] ? hms_x : nhms_x;
      ex_x = ldx_ff[robi_pkg::LW-1] ? nhms_x : hms_x;
      en_y = ldy_ff[robi_pkg::LW-1] ? hms_y : nhms_y;
      ex_y = ldy_ff[robi_pkg::LW-1] ? nhms_y : hms_y;
      nums = {ex_y, en_y, ex_x, en_x};
      in_x = (sx > -hx) && (sx < hx);
      in_y = (sy > -hy) && (sy < hy);
      dv0_in.side.c = c3_ff;
      dv0_in.side.s = s3_ff;
      dv0_in.side.dx_neg = ldx_ff[robi_pkg::LW-1];
      dv0_in.side.dy_neg = ldy_ff[robi_pkg::LW-1];
      dv0_in.side.zx = (ldx_ff == '0);
      dv0_in.side.zy = (ldy_ff == '0);
      dv0_in.side.miss = (dv0_in.side.zx && !in_x) || (dv0_in.side.zy && !in_y);
      dv0_in.dvs[0] = ldx_ff[robi_pkg::LW-1] ? robi_pkg::LW'(-ldx_ff) : ldx_ff;
      dv0_in.dvs[1] = ldy_ff[robi_pkg::LW-1] ? robi_pkg::LW'(-ldy_ff) : ldy_ff;
      for (int i = 0; i < 4; i++) begin
         dv0_in.side.q_neg[i] = nums[i][robi_pkg::NW-1] ^ dv0_in.side.dx_neg;
         if (i >= 2) begin
            dv0_in.side.q_neg[i] = nums[i][robi_pkg::NW-1] ^ dv0_in.side.dy_neg;
         end
         dv0_in.rem[i] = '0;
         dv0_in.quo[i] = nums[i][robi_pkg::NW-1]
                         ? {robi_pkg::LW'(-$signed(nums[i])), robi_pkg::FB'(0)}
                         : {robi_pkg::LW'(nums[i]), robi_pkg::FB'(0)};
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         dv_ff[0] <= dv0_in;
      end
   end

   // Divider: one restoring step, one quotient bit, per stage.
   for (genvar k = 1; k <= robi_pkg::DIV_BITS; k++) begin : g_div
      robi_pkg::div_type dv_in;

      always_comb begin
         logic [robi_pkg::LW:0] t, dd;
         dv_in = dv_ff[k-1];
         for (int i = 0; i < 4; i++) begin
            t = {dv_ff[k-1].rem[i], dv_ff[k-1].quo[i][robi_pkg::QW-1]};
            dd = {1'b0, dv_ff[k-1].dvs[i >> 1]};
            if (t >= dd) begin
               dv_in.rem[i] = robi_pkg::LW'(t - dd);
               dv_in.quo[i] = {dv_ff[k-1].quo[i][robi_pkg::QW-2:0], 1'b1};
            end else begin
               dv_in.rem[i] = t[robi_pkg::LW-1:0];
               dv_in.quo[i] = {dv_ff[k-1].quo[i][robi_pkg::QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[3+k]) begin
            dv_ff[k] <= dv_in;
         end
      end
   end

   // Signed fractions, with open slabs as infinite bounds.
   logic signed [robi_pkg::TW-1:0] t_ff [4];
   logic signed [robi_pkg::TW-1:0] t_in [4];
   robi_pkg::side_type             sd5_ff;

   always_comb begin
      logic signed [robi_pkg::TW-1:0] mag;
      logic                           open;
      for (int i = 0; i < 4; i++) begin
         mag = $signed({3'b0, dv_ff[robi_pkg::DIV_BITS].quo[i]});
         open = (i < 2) ? dv_ff[robi_pkg::DIV_BITS].side.zx
                        : dv_ff[robi_pkg::DIV_BITS].side.zy;
         if (open) begin
            t_in[i] = (i % 2 == 0) ? -robi_pkg::T_INF : robi_pkg::T_INF;
         end else begin
            t_in[i] = dv_ff[robi_pkg::DIV_BITS].side.q_neg[i] ? -mag : mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[SD+1]) begin
         t_ff   <= t_in;
         sd5_ff <= dv_ff[robi_pkg::DIV_BITS].side;
      end
   end

   // Entry and exit selection.
   logic signed [robi_pkg::TW-1:0] entry_ff, exit_ff;
   logic                           xsel_ff, early_miss_ff, sg_ff;
   logic signed [robi_pkg::RW-1:0] c6_ff, s6_ff;

   always_ff @(posedge clock) begin
      if (en[SD+2]) begin
         xsel_ff  <= t_ff[0] > t_ff[2];
         entry_ff <= (t_ff[0] > t_ff[2]) ? t_ff[0] : t_ff[2];
         exit_ff  <= (t_ff[1] < t_ff[3]) ? t_ff[1] : t_ff[3];
         early_miss_ff <= sd5_ff.miss
                          || (t_ff[0] <= 0 && t_ff[2] <= 0)
                          || (t_ff[1] <= 0 && t_ff[3] <= 0);
         sg_ff <= (t_ff[0] > t_ff[2]) ? sd5_ff.dx_neg : sd5_ff.dy_neg;
         c6_ff <= sd5_ff.c;
         s6_ff <= sd5_ff.s;
      end
   end

   // Result word.
   logic                           hit_ff, hit_in;
   logic [robi_pkg::HFW-1:0]       frac_ff, frac_in;
   logic signed [robi_pkg::RW-1:0] nx_ff, ny_ff, nx_in, ny_in;

   always_comb begin
      hit_in = !(early_miss_ff || entry_ff > exit_ff || entry_ff > robi_pkg::FRAC_ONE);
      frac_in = '0;
      nx_in = '0;
      ny_in = '0;
      if (hit_in) begin
         frac_in = entry_ff[robi_pkg::HFW-1:0];
         if (xsel_ff) begin
            nx_in = sg_ff ? -c6_ff : c6_ff;
            ny_in = sg_ff ? -s6_ff : s6_ff;
         end else begin
            nx_in = sg_ff ? s6_ff : -s6_ff;
            ny_in = sg_ff ? -c6_ff : c6_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST-1]) begin
         hit_ff  <= hit_in;
         frac_ff <= frac_in;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
      end
   end

   assign rsp_tuser = hit_ff;
   assign rsp_tdata = {7'b0, ny_ff, nx_ff, frac_ff};

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 61;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_WORDS = 550;

   typedef struct packed {
      logic signed [31:0] sx, sy, fx, fy, cx, cy;
      logic [30:0]        w, h;
      logic signed [15:0] c, s;
   } query_type;

   typedef struct packed {
      logic               hit;
      logic [16:0]        frac;
      logic signed [15:0] nx, ny;
   } answer_type;

   typedef struct {
      query_type  q;
      logic       known;
      answer_type a;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [287:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;

   answer_type expected_answers[$];
   int  errors = 0;
   int  idle_cycles = 0;
   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;

   ray_oriented_box_intersection dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic longint to_q17(longint v);
      return (v + 64'sd4096) >>> 13;
   endfunction

   function automatic bit slab_span(longint st, longint d, longint h,
                                    output longint en, output longint ex);
      longint a, b;
      if (d == 0) begin
         en = -(64'sd1 <<< 62);
         ex = 64'sd1 <<< 62;
         return (st > -h) && (st < h);
      end
      a = ((h - st) * 65536) / d;
      b = ((-h - st) * 65536) / d;
      if (d < 0) begin
         en = a;
         ex = b;
      end else begin
         en = b;
         ex = a;
      end
      return 1'b1;
   endfunction

   function automatic answer_type intersect_box(query_type q);
      answer_type r;
      longint c, s, px, py, dx, dy, lsx, lsy, ldx, ldy;
      longint enx, exx, eny, exy, entry, leave, sg;
      r = '0;
      c = q.c;
      s = q.s;
      px = longint'(q.sx) - longint'(q.cx);
      py = longint'(q.sy) - longint'(q.cy);
      dx = longint'(q.fx) - longint'(q.sx);
      dy = longint'(q.fy) - longint'(q.sy);
      lsx = to_q17(px * c + py * s);
      lsy = to_q17(py * c - px * s);
      ldx = to_q17(dx * c + dy * s);
      ldy = to_q17(dy * c - dx * s);
      if (!slab_span(lsx, ldx, longint'(q.w), enx, exx)) return r;
      if (!slab_span(lsy, ldy, longint'(q.h), eny, exy)) return r;
      if ((enx <= 0 && eny <= 0) || (exx <= 0 && exy <= 0)) return r;
      entry = enx > eny ? enx : eny;
      leave = exx < exy ? exx : exy;
      if (entry > leave || entry > 65536) return r;
      r.hit = 1'b1;
      r.frac = entry[16:0];
      if (enx > eny) begin
         sg = ldx < 0 ? -1 : 1;
         r.nx = 16'(sg * c);
         r.ny = 16'(sg * s);
      end else begin
         sg = ldy < 0 ? -1 : 1;
         r.nx = 16'(-sg * s);
         r.ny = 16'(sg * c);
      end
      return r;
   endfunction

   function automatic logic [287:0] pack_query(query_type q);
      return {2'b0, q.s, q.c, q.h, q.w, q.cy, q.cx, q.fy, q.fx, q.sy, q.sx};
   endfunction

   function automatic query_type make_query(int sx, int sy, int fx, int fy, int cx,
                                            int cy, int w, int h, int c, int s);
      query_type q;
      q.sx = sx; q.sy = sy; q.fx = fx; q.fy = fy; q.cx = cx; q.cy = cy;
      q.w = 31'(w); q.h = 31'(h); q.c = 16'(c); q.s = 16'(s);
      return q;
   endfunction

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   function automatic query_type random_query();
      query_type q;
      int k;
      q.cx = random_coord();
      q.cy = random_coord();
      if ($urandom_range(0, 3) != 0) begin
         q.sx = q.cx + 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         q.sy = q.cy + 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         q.fx = q.cx + 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         q.fy = q.cy + 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         q.w = 31'($urandom_range(0, 8 << 16));
         q.h = 31'($urandom_range(0, 8 << 16));
         if ($urandom_range(0, 4) == 0) q.fx = q.sx;
         if ($urandom_range(0, 4) == 0) q.fy = q.sy;
      end else begin
         q.sx = random_coord();
         q.sy = random_coord();
         q.fx = random_coord();
         q.fy = random_coord();
         q.w = 31'($urandom());
         q.h = 31'($urandom());
      end
      k = $urandom_range(0, 7);
      case (k)
         0: begin q.c = 16'sd16384; q.s = 16'sd0; end
         1: begin q.c = 16'sd0; q.s = -16'sd16384; end
         2: begin q.c = 16'($urandom()); q.s = 16'($urandom()); end
         default: begin
            q.c = 16'($signed($urandom_range(0, 32768)) - 16384);
            q.s = 16'($signed($urandom_range(0, 32768)) - 16384);
         end
      endcase
      return q;
   endfunction

   task automatic send_word(query_type q);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= pack_query(q);
      req_tvalid <= 1'b1;
      expected_answers.push_back(intersect_box(q));
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_row(stim_row_type row);
      if (row.known && row.a != intersect_box(row.q)) begin
         $display("%0t table row disagrees with predictor: %h", $time, row.a);
         errors++;
      end
      send_word(row.q);
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);

   always @(posedge clock) begin
      answer_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.hit = rsp_tuser;
            got.frac = rsp_tdata[16:0];
            got.nx = rsp_tdata[32:17];
            got.ny = rsp_tdata[48:33];
            if (expected_answers.size() == 0) begin
               $display("%0t unexpected word: actual %h", $time, got);
               errors++;
            end else begin
               want = expected_answers.pop_front();
               if (got.hit !== want.hit || got.frac !== want.frac ||
                   got.nx !== want.nx || got.ny !== want.ny || rsp_tdata[55:49] !== '0) begin
                  $display("%0t mismatch: expected hit %b frac %0d n %0d,%0d actual hit %b frac %0d n %0d,%0d",
                           $time, want.hit, want.frac, want.nx, want.ny,
                           got.hit, got.frac, got.nx, got.ny);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      int phase;
      int guard;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Unit box at the origin, axis aligned, ray along +x from -2 to +2.
      row = '{make_query(-2 << 16, 0, 2 << 16, 0, 0, 0, 1 << 16, 1 << 16, 16384, 0),
              1'b1, '{1'b1, 17'd24576, 16'sd16384, 16'sd0}}; rows.push_back(row);
      // Same ray reversed hits the +x face.
      row = '{make_query(2 << 16, 0, -2 << 16, 0, 0, 0, 1 << 16, 1 << 16, 16384, 0),
              1'b1, '{1'b1, 17'd24576, -16'sd16384, 16'sd0}}; rows.push_back(row);
      // Ray along +y, enters the bottom face.
      row = '{make_query(0, -2 << 16, 0, 2 << 16, 0, 0, 1 << 16, 1 << 16, 16384, 0),
              1'b1, '{1'b1, 17'd24576, 16'sd0, 16'sd16384}}; rows.push_back(row);
      // Zero direction on y with the start on the slab edge misses.
      row = '{make_query(-2 << 16, 1 << 15, 2 << 16, 1 << 15, 0, 0, 1 << 16, 1 << 16, 16384, 0),
              1'b1, '0}; rows.push_back(row);
      // Degenerate point ray inside the box misses since no entry is positive.
      row = '{make_query(0, 0, 0, 0, 0, 0, 1 << 16, 1 << 16, 16384, 0), 1'b1, '0};
      rows.push_back(row);
      // Segment stops short of the box: entry beyond one.
      row = '{make_query(-4 << 16, 0, -3 << 16, 0, 0, 0, 1 << 16, 1 << 16, 16384, 0),
              1'b1, '0}; rows.push_back(row);
      // Box behind the ray.
      row = '{make_query(2 << 16, 0, 4 << 16, 0, 0, 0, 1 << 16, 1 << 16, 16384, 0),
              1'b1, '0}; rows.push_back(row);
      // Zero-size box.
      row = '{make_query(-2 << 16, 0, 2 << 16, 0, 0, 0, 0, 0, 16384, 0), 1'b1, '0};
      rows.push_back(row);
      // Rotated by a quarter and an eighth turn, out-of-range orientation, field extremes and a near-vertical ray.
      rows.push_back('{make_query(-2 << 16, 0, 2 << 16, 0, 0, 0, 1 << 16, 2 << 16, 0, 16384),
                       1'b0, '0});
      rows.push_back('{make_query(-2 << 16, 1, 2 << 16, 3, 0, 0, 1 << 16, 1 << 16, 11585, 11585),
                       1'b0, '0});
      rows.push_back('{make_query(-2 << 16, 0, 2 << 16, 0, 0, 0, 1 << 16, 1 << 16, -32768, 32767),
                       1'b0, '0});
      rows.push_back('{make_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -16384, -16384), 1'b0, '0});
      rows.push_back('{make_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 16384, 16384),
                       1'b0, '0});
      rows.push_back('{make_query(-1, -1, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                                  -1, 1), 1'b0, '0});
      rows.push_back('{make_query(0, -2 << 16, 3, 2 << 16, 0, 0, 1 << 16, 1 << 16, 16384, 0),
                       1'b0, '0});
      foreach (rows[i]) send_row(rows[i]);
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_answers.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 52 : 0;
         receiver_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 18 : 0;
         repeat (RANDOM_WORDS / 3) send_word(random_query());
      end
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_answers.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (LATENCY + 10) @(negedge clock);
      if (errors == 0 && expected_answers.size() == 0) begin
         $display("TB_OK");
      end else begin
         if (expected_answers.size() != 0)
            $display("%0t %0d expected words never arrived", $time, expected_answers.size());
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
